// ----- rtl/core/kar_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kar_pkg
// Shared types, constants and helpers for the angle/rate Kalman filter.
// ----------------------------------------------------------------------------
package kar_pkg;

    localparam int A_W     = 32;   // angle, rate, accel (Q16.16)
    localparam int P_W     = 40;   // covariance entries (Q8.32)
    localparam int DT_W    = 33;   // time step (unsigned Q1.32)
    localparam int DTUS_W  = 20;   // microsecond count
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int MAG_W   = 64;   // operand magnitude width
    localparam int SUM_W   = 66;   // wide signed working width
    localparam int DIV_NW  = 73;   // dividend / quotient width
    localparam int DIV_DW  = 40;   // divisor width
    localparam int DIV_CW  = 7;
    localparam int STEP_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_QA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_R  = 2'd2;

    localparam logic [CFG_W-1:0] QA_RST = 32'd4294967;
    localparam logic [CFG_W-1:0] QR_RST = 32'd12884902;
    localparam logic [CFG_W-1:0] R_RST  = 32'd128849019;

    // 2^32 = 4294 * 10^6 + 967296; 10^6 = 64 * 15625
    localparam logic [12:0]       US_WHOLE  = 13'd4294;
    localparam logic [DTUS_W-1:0] US_FRAC   = 20'd967296;
    localparam logic [39:0]       US_HALF   = 40'd500000;
    localparam logic [34:0]       US_RCP    = 35'd18014398510;  // ceil(2^48 / 15625)
    localparam logic [62:0]       LIM62     = 63'h4000000000000000;
    localparam logic [STEP_W-1:0] LAST_STEP = 4'd14;

    typedef enum logic [3:0] {
        MOP_DT_ACC_H, MOP_DT_T_ANG, MOP_DT_ACC, MOP_DT_P3, MOP_DT_T_P0, MOP_QR_DT,
        MOP_K0_Y, MOP_K1_Y, MOP_K0_P0, MOP_K0_P1, MOP_K1_P0, MOP_K1_P1
    } t_mop;

    typedef enum logic [1:0] {DOP_DT, DOP_K0, DOP_K1} t_dop;

    typedef struct packed {
        logic is_div;
        t_mop mop;
        t_dop dop;
    } t_step;

    typedef struct packed {
        logic load;
        logic mul_start;
        logic mul_wb;
        logic div_start;
        logic div_wb;
        logic store;
        t_mop mop;
        t_dop dop;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic out_busy;
    } t_dp_sts;

    // micro-op sequence of one update
    function automatic t_step step_info(input logic [STEP_W-1:0] step);
        t_step s;
        s = '{is_div: 1'b0, mop: MOP_DT_ACC_H, dop: DOP_DT};
        case (step)
            4'd0:  s = '{is_div: 1'b1, mop: MOP_DT_ACC_H, dop: DOP_DT};
            4'd1:  s.mop = MOP_DT_ACC_H;
            4'd2:  s.mop = MOP_DT_T_ANG;
            4'd3:  s.mop = MOP_DT_ACC;
            4'd4:  s.mop = MOP_DT_P3;
            4'd5:  s.mop = MOP_DT_T_P0;
            4'd6:  s.mop = MOP_QR_DT;
            4'd7:  s = '{is_div: 1'b1, mop: MOP_DT_ACC_H, dop: DOP_K0};
            4'd8:  s = '{is_div: 1'b1, mop: MOP_DT_ACC_H, dop: DOP_K1};
            4'd9:  s.mop = MOP_K0_Y;
            4'd10: s.mop = MOP_K1_Y;
            4'd11: s.mop = MOP_K0_P0;
            4'd12: s.mop = MOP_K0_P1;
            4'd13: s.mop = MOP_K1_P0;
            4'd14: s.mop = MOP_K1_P1;
            default: s.mop = MOP_DT_ACC_H;
        endcase
        return s;
    endfunction

    function automatic logic signed [A_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(64'sh7fffffff);
        lo = -hi - SUM_W'(1);
        if (v > hi) return 32'sh7fffffff;
        else if (v < lo) return 32'sh80000000;
        else return A_W'(v);
    endfunction

    function automatic logic signed [P_W-1:0] sat40(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(64'sh7fffffffff);
        lo = -hi - SUM_W'(1);
        if (v > hi) return 40'sh7fffffffff;
        else if (v < lo) return 40'sh8000000000;
        else return P_W'(v);
    endfunction

    function automatic logic [MAG_W-1:0] mag(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] n;
        n = -v;
        return v[SUM_W-1] ? MAG_W'(n) : MAG_W'(v);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/kar_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kar_in_if / kar_out_if
// Valid/ready channels carrying filter input and result items.
// ----------------------------------------------------------------------------
interface kar_in_if;
    logic               valid;
    logic               ready;
    logic               axis;
    logic signed [31:0] measured_angle;
    logic signed [31:0] accel;
    logic        [19:0] dt_us;

    modport source (output valid, axis, measured_angle, accel, dt_us, input ready);
    modport sink   (input valid, axis, measured_angle, accel, dt_us, output ready);
endinterface

interface kar_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] filtered_angle;
    logic signed [31:0] rate_estimate;

    modport source (output valid, filtered_angle, rate_estimate, input ready);
    modport sink   (input valid, filtered_angle, rate_estimate, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/kalman_angle_rate_filter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kalman_angle_rate_filter
// Two-state angle/rate Kalman filter with one state set per axis.
// ----------------------------------------------------------------------------
// channel   dir  payload
// i_in      in   axis, measured_angle, accel, dt_us
// o_out     out  filtered_angle, rate_estimate
// i_cfg_*   in   write enable, register index, 32-bit data
//
// An item goes from accept to result through the time step by a
// reciprocal multiply, two 73-bit gain divisions on the
// bit-serial divider, twelve products on the four-pass
// 32x32 multiplier and a store of the result.
// One item is in work at a time, so a new item is accepted only once the
// previous one is stored, even while its result still waits in the
// output register; a result left waiting stalls the next store.
// Synchronous reset zeroes all axis state and loads the noise defaults.
// ----------------------------------------------------------------------------
module kalman_angle_rate_filter
    import kar_pkg::*;
#(
    parameter int NUM_AXES = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    kar_in_if.sink                    i_in,
    kar_out_if.source                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    assign i_in.ready = w_in_ready;

    kar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    kar_datapath #(
        .NUM_AXES (NUM_AXES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_axis           (i_in.axis),
        .i_measured_angle (i_in.measured_angle),
        .i_accel          (i_in.accel),
        .i_dt_us          (i_in.dt_us),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_filtered_angle (o_out.filtered_angle),
        .o_rate_estimate  (o_out.rate_estimate)
    );

endmodule
`default_nettype wire

// ----- rtl/core/kar_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kar_mul
// Sequential 64x64 magnitude multiplier, four 32x32 partial products,
// with round-half-away, shift by 32 or 33 and clamp to 2^62.
// ----------------------------------------------------------------------------
module kar_mul
    import kar_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [MAG_W-1:0]        i_a,
    input  wire logic [MAG_W-1:0]        i_b,
    input  wire logic                    i_neg,
    input  wire logic                    i_s33,
    output      logic                    o_done,
    output      logic signed [MAG_W-1:0] o_res
);

    localparam logic [2:0] PH_LAST_PP = 3'd3;
    localparam logic [2:0] PH_LAST_ACC = 3'd4;
    localparam logic [2:0] PH_FIN = 3'd5;

    logic                    r_busy;
    logic                    r_done;
    logic [2:0]              r_ph;
    logic [MAG_W-1:0]        r_a;
    logic [MAG_W-1:0]        r_b;
    logic                    r_neg;
    logic                    r_s33;
    logic [MAG_W-1:0]        r_pp;
    logic [1:0]              r_pp_sh;
    logic [127:0]            r_acc;
    logic signed [MAG_W-1:0] r_res;

    logic [31:0]  w_ah;
    logic [31:0]  w_bh;
    logic [1:0]   w_sh;
    logic [63:0]  w_pp;
    logic [127:0] w_pp_al;
    logic [128:0] w_rnd;
    logic [95:0]  w_shf;
    logic [62:0]  w_mag;

    always_comb begin
        case (r_ph[1:0])
            2'd0: begin w_ah = r_a[31:0];  w_bh = r_b[31:0];  w_sh = 2'd0; end
            2'd1: begin w_ah = r_a[31:0];  w_bh = r_b[63:32]; w_sh = 2'd1; end
            2'd2: begin w_ah = r_a[63:32]; w_bh = r_b[31:0];  w_sh = 2'd1; end
            default: begin w_ah = r_a[63:32]; w_bh = r_b[63:32]; w_sh = 2'd2; end
        endcase
        w_pp = 64'(w_ah) * 64'(w_bh);
        case (r_pp_sh)
            2'd0: w_pp_al = {64'd0, r_pp};
            2'd1: w_pp_al = {32'd0, r_pp, 32'd0};
            default: w_pp_al = {r_pp, 64'd0};
        endcase
        w_rnd = {1'b0, r_acc} + (r_s33 ? (129'd1 << 32) : (129'd1 << 31));
        w_shf = r_s33 ? 96'(w_rnd >> 33) : 96'(w_rnd >> 32);
        w_mag = (w_shf > 96'(LIM62)) ? LIM62 : w_shf[62:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_ph   <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_neg  <= i_neg;
                r_s33  <= i_s33;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_ph <= r_ph + 3'd1;
                if (r_ph <= PH_LAST_PP) begin
                    r_pp    <= w_pp;
                    r_pp_sh <= w_sh;
                end
                if (r_ph != 3'd0 && r_ph <= PH_LAST_ACC) begin
                    r_acc <= r_acc + w_pp_al;
                end
                if (r_ph == PH_FIN) begin
                    r_res  <= r_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
`default_nettype wire

// ----- rtl/core/kar_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kar_div
// Restoring divider, one quotient bit per cycle, unsigned 73 / 40 bits.
// ----------------------------------------------------------------------------
module kar_div
    import kar_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_NW-1:0] i_num,
    input  wire logic [DIV_DW-1:0] i_den,
    output      logic              o_done,
    output      logic [DIV_NW-1:0] o_quo
);

    localparam logic [DIV_CW-1:0] CNT_LAST = DIV_CW'(DIV_NW - 1);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_NW-1:0] r_quo;

    logic [DIV_DW:0] w_rem_sh;
    logic            w_ge;
    logic [DIV_DW:0] w_diff;

    always_comb begin
        w_rem_sh = {r_rem, r_quo[DIV_NW-1]};
        w_ge     = w_rem_sh >= {1'b0, r_den};
        w_diff   = w_rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_den;
                r_quo  <= i_num;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DIV_DW-1:0] : w_rem_sh[DIV_DW-1:0];
                r_quo <= {r_quo[DIV_NW-2:0], w_ge};
                r_cnt <= r_cnt + DIV_CW'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

// ----- rtl/core/kar_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kar_datapath
// Per-axis state, working registers, config registers, shared multiplier
// and divider, result register.
// ----------------------------------------------------------------------------
module kar_datapath
    import kar_pkg::*;
#(
    parameter int NUM_AXES = 2
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    output      t_dp_sts                 o_sts,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_W-1:0]        i_cfg_wdata,
    input  wire logic                    i_axis,
    input  wire logic signed [A_W-1:0]   i_measured_angle,
    input  wire logic signed [A_W-1:0]   i_accel,
    input  wire logic [DTUS_W-1:0]       i_dt_us,
    output      logic                    o_out_valid,
    input  wire logic                    i_out_ready,
    output      logic signed [A_W-1:0]   o_filtered_angle,
    output      logic signed [A_W-1:0]   o_rate_estimate
);

    localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    logic [CFG_W-1:0] r_cfg_qa;
    logic [CFG_W-1:0] r_cfg_qr;
    logic [CFG_W-1:0] r_cfg_r;

    logic signed [A_W-1:0] r_ang_st [NUM_AXES];
    logic signed [A_W-1:0] r_vel_st [NUM_AXES];
    logic signed [P_W-1:0] r_cov_st [NUM_AXES][4];

    logic [AXW-1:0]          r_ax;
    logic signed [A_W-1:0]   r_meas;
    logic signed [A_W-1:0]   r_acc;
    logic [DTUS_W-1:0]       r_dtus;
    logic [DT_W-1:0]         r_dt;
    logic signed [A_W-1:0]   r_ang;
    logic signed [A_W-1:0]   r_vel;
    logic signed [P_W-1:0]   r_p [4];
    logic signed [SUM_W-1:0] r_t;
    logic signed [A_W:0]     r_y;
    logic signed [MAG_W-1:0] r_k0;
    logic signed [MAG_W-1:0] r_k1;
    logic                    r_s_pos;

    logic                  r_out_valid;
    logic signed [A_W-1:0] r_out_ang;
    logic signed [A_W-1:0] r_out_vel;

    // time step unit: registered reciprocal multiply
    logic [1:0]      r_dq_ph;
    logic            r_dq_done;
    logic [33:0]     r_dq_y;
    logic [51:0]     r_dq_lo;
    logic [50:0]     r_dq_hi;
    logic [DT_W-1:0] r_dq_dt;

    logic [AXW-1:0]          w_ax;
    logic signed [SUM_W-1:0] w_opa;
    logic signed [SUM_W-1:0] w_opb;
    logic                    w_s33;
    logic                    w_mul_done;
    logic signed [MAG_W-1:0] w_mres;
    logic signed [SUM_W-1:0] w_m;
    logic signed [SUM_W-1:0] w_dt_s;
    logic signed [P_W:0]     w_s;
    logic [MAG_W-1:0]        w_pm;
    logic [DIV_NW-1:0]       w_num;
    logic [DIV_DW-1:0]       w_den;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [DIV_NW-1:0]       w_quo;
    logic [62:0]             w_qc;
    logic                    w_gneg;
    logic signed [MAG_W-1:0] w_gain;
    logic                    w_dq_start;
    logic [39:0]             w_dq_x;
    logic [68:0]             w_dq_prod;
    logic [20:0]             w_dq_q;
    logic [DT_W-1:0]         w_dq_dt;

    assign w_ax   = (NUM_AXES > 1) ? AXW'(i_axis) : '0;
    assign w_dt_s = SUM_W'($signed({1'b0, r_dt}));
    assign w_m    = SUM_W'(w_mres);
    assign w_s    = (P_W+1)'(r_p[0]) + (P_W+1)'($signed({1'b0, r_cfg_r}));

    // dt = dt_us * 4294 + (dt_us * 967296 + 500000) / 10^6
    assign w_dq_start  = i_cmd.div_start && (i_cmd.dop == DOP_DT);
    assign w_div_start = i_cmd.div_start && (i_cmd.dop != DOP_DT);
    assign w_dq_x      = 40'(r_dtus) * 40'(US_FRAC) + US_HALF;
    assign w_dq_prod   = (69'(r_dq_hi) << 18) + 69'(r_dq_lo);
    assign w_dq_q      = w_dq_prod[68:48];
    assign w_dq_dt     = DT_W'(r_dtus) * DT_W'(US_WHOLE) + DT_W'(w_dq_q);

    // multiplier operand selection
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        w_s33 = 1'b0;
        case (i_cmd.mop)
            MOP_DT_ACC_H: begin w_opa = w_dt_s; w_opb = SUM_W'(r_acc); w_s33 = 1'b1; end
            MOP_DT_T_ANG: begin w_opa = w_dt_s; w_opb = r_t; end
            MOP_DT_ACC:   begin w_opa = w_dt_s; w_opb = SUM_W'(r_acc); end
            MOP_DT_P3:    begin w_opa = w_dt_s; w_opb = SUM_W'(r_p[3]); end
            MOP_DT_T_P0:  begin w_opa = w_dt_s; w_opb = r_t; end
            MOP_QR_DT:    begin w_opa = SUM_W'($signed({1'b0, r_cfg_qr})); w_opb = w_dt_s; end
            MOP_K0_Y:     begin w_opa = SUM_W'(r_k0); w_opb = SUM_W'(r_y); end
            MOP_K1_Y:     begin w_opa = SUM_W'(r_k1); w_opb = SUM_W'(r_y); end
            MOP_K0_P0:    begin w_opa = SUM_W'(r_k0); w_opb = SUM_W'(r_p[0]); end
            MOP_K0_P1:    begin w_opa = SUM_W'(r_k0); w_opb = SUM_W'(r_p[1]); end
            MOP_K1_P0:    begin w_opa = SUM_W'(r_k1); w_opb = SUM_W'(r_p[0]); end
            MOP_K1_P1:    begin w_opa = SUM_W'(r_k1); w_opb = SUM_W'(r_p[1]); end
            default: begin w_opa = '0; w_opb = '0; end
        endcase
    end

    // divider operand selection and gain sign/clamp
    always_comb begin
        w_pm   = mag(SUM_W'((i_cmd.dop == DOP_K1) ? r_p[2] : r_p[0]));
        w_num  = DIV_NW'({w_pm[P_W-1:0], 32'd0});
        w_den  = w_s[DIV_DW-1:0];
        w_qc   = (w_quo >= DIV_NW'(LIM62)) ? LIM62 : w_quo[62:0];
        w_gneg = (i_cmd.dop == DOP_K1) ? r_p[2][P_W-1] : r_p[0][P_W-1];
        if (!r_s_pos) w_gain = '0;
        else if (w_gneg) w_gain = -$signed({1'b0, w_qc});
        else w_gain = $signed({1'b0, w_qc});
    end

    kar_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mag(w_opa)),
        .i_b     (mag(w_opb)),
        .i_neg   (w_opa[SUM_W-1] ^ w_opb[SUM_W-1]),
        .i_s33   (w_s33),
        .o_done  (w_mul_done),
        .o_res   (w_mres)
    );

    kar_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // time step: floor(y * ceil(2^48 / 15625) / 2^48) with y below 2^34
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dq_ph   <= 2'd0;
            r_dq_done <= 1'b0;
        end else begin
            r_dq_done <= 1'b0;
            if (w_dq_start) begin
                r_dq_y  <= w_dq_x[39:6];
                r_dq_ph <= 2'd1;
            end else if (r_dq_ph == 2'd1) begin
                r_dq_lo <= 52'(r_dq_y) * 52'(US_RCP[17:0]);
                r_dq_hi <= 51'(r_dq_y) * 51'(US_RCP[34:18]);
                r_dq_ph <= 2'd2;
            end else if (r_dq_ph == 2'd2) begin
                r_dq_dt   <= w_dq_dt;
                r_dq_done <= 1'b1;
                r_dq_ph   <= 2'd0;
            end
        end
    end

    // config registers and per-axis stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_qa <= QA_RST;
            r_cfg_qr <= QR_RST;
            r_cfg_r  <= R_RST;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_ang_st[i] <= '0;
                r_vel_st[i] <= '0;
                for (int j = 0; j < 4; j++) begin
                    r_cov_st[i][j] <= '0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_QA:  r_cfg_qa <= i_cfg_wdata;
                    CFG_QR:  r_cfg_qr <= i_cfg_wdata;
                    CFG_R:   r_cfg_r  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.store) begin
                r_ang_st[r_ax] <= r_ang;
                r_vel_st[r_ax] <= r_vel;
                for (int j = 0; j < 4; j++) begin
                    r_cov_st[r_ax][j] <= r_p[j];
                end
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax   <= w_ax;
            r_meas <= i_measured_angle;
            r_acc  <= i_accel;
            r_dtus <= i_dt_us;
            r_ang  <= r_ang_st[w_ax];
            r_vel  <= r_vel_st[w_ax];
            for (int j = 0; j < 4; j++) begin
                r_p[j] <= r_cov_st[w_ax][j];
            end
        end
        if (i_cmd.div_start) begin
            r_s_pos <= w_s > 0;
        end
        if (i_cmd.div_wb) begin
            case (i_cmd.dop)
                DOP_DT:  r_dt <= r_dq_dt;
                DOP_K0:  r_k0 <= w_gain;
                DOP_K1:  r_k1 <= w_gain;
                default: ;
            endcase
        end
        if (i_cmd.mul_wb) begin
            case (i_cmd.mop)
                MOP_DT_ACC_H: r_t <= SUM_W'(r_vel) + w_m;
                MOP_DT_T_ANG: r_ang <= sat32(SUM_W'(r_ang) + w_m);
                MOP_DT_ACC: begin
                    r_vel <= sat32(SUM_W'(r_vel) + w_m);
                    r_y   <= (A_W+1)'(r_meas) - (A_W+1)'(r_ang);
                end
                MOP_DT_P3: begin
                    r_t    <= w_m + SUM_W'(r_p[1]) + SUM_W'(r_p[2])
                              + SUM_W'($signed({1'b0, r_cfg_qa}));
                    r_p[1] <= sat40(SUM_W'(r_p[1]) + w_m);
                    r_p[2] <= sat40(SUM_W'(r_p[2]) + w_m);
                end
                MOP_DT_T_P0: r_p[0] <= sat40(SUM_W'(r_p[0]) + w_m);
                MOP_QR_DT:   r_p[3] <= sat40(SUM_W'(r_p[3]) + w_m);
                MOP_K0_Y:    r_ang  <= sat32(SUM_W'(r_ang) + w_m);
                MOP_K1_Y:    r_vel  <= sat32(SUM_W'(r_vel) + w_m);
                MOP_K0_P0:   r_p[0] <= sat40(SUM_W'(r_p[0]) - w_m);
                MOP_K0_P1:   r_p[1] <= sat40(SUM_W'(r_p[1]) - w_m);
                MOP_K1_P0:   r_p[2] <= sat40(SUM_W'(r_p[2]) - w_m);
                MOP_K1_P1:   r_p[3] <= sat40(SUM_W'(r_p[3]) - w_m);
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.store) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.store) begin
            r_out_ang <= r_ang;
            r_out_vel <= r_vel;
        end
    end

    assign o_sts.mul_done   = w_mul_done;
    assign o_sts.div_done   = w_div_done || r_dq_done;
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_filtered_angle = r_out_ang;
    assign o_rate_estimate  = r_out_vel;

endmodule
`default_nettype wire

// ----- rtl/core/kar_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kar_ctrl
// Sequencer: walks the micro-op list of one update, starting the shared
// multiplier, the divider or the time step unit and committing each result.
// ----------------------------------------------------------------------------
module kar_ctrl
    import kar_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output      logic    o_in_ready,
    output      t_dp_cmd o_cmd,
    input  wire t_dp_sts i_sts
);

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_STORE} t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    t_step             w_info;
    logic              w_done;

    always_comb begin
        w_info = step_info(r_step);
        w_done = w_info.is_div ? i_sts.div_done : i_sts.mul_done;
        o_cmd.mop       = w_info.mop;
        o_cmd.dop       = w_info.dop;
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul_start = (r_state == S_ISSUE) && !w_info.is_div;
        o_cmd.div_start = (r_state == S_ISSUE) && w_info.is_div;
        o_cmd.mul_wb    = (r_state == S_WAIT) && !w_info.is_div && i_sts.mul_done;
        o_cmd.div_wb    = (r_state == S_WAIT) && w_info.is_div && i_sts.div_done;
        o_cmd.store     = (r_state == S_STORE) && !i_sts.out_busy;
        o_in_ready      = (r_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_step  <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_done) begin
                        if (r_step == LAST_STEP) begin
                            r_state <= S_STORE;
                        end else begin
                            r_step  <= r_step + STEP_W'(1);
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_STORE: begin
                    if (!i_sts.out_busy) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.mul_start && o_cmd.div_start))
        else $error("multiplier and divider started together");

    a_mul_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.mul_done |-> (r_state == S_WAIT) && !w_info.is_div)
        else $error("multiplier finished outside a multiply step");

    a_div_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_WAIT) && w_info.is_div)
        else $error("divider finished outside a divide step");

    a_issue_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.mul_start || o_cmd.div_start) |=> (r_state == S_WAIT))
        else $error("unit started without waiting for it");

endmodule
`default_nettype wire
